[rtl/core/sds_pkg.sv]
// package for the scan disk scheduler
// widths, register indexes and controller/datapath command and status types
// no dependencies
`default_nettype none

package sds_pkg;

  localparam int DATA_W           = 16;
  localparam int SEEK_W           = 21;
  localparam int MAX_REQUESTS_DEF = 16;
  localparam int CFG_ADDR_W       = 3;
  localparam int CFG_DATA_W       = 32;

  localparam logic [DATA_W-1:0] START_RESET = 16'd0;
  localparam logic [DATA_W-1:0] END_RESET   = 16'd199;

  localparam logic REG_START = 1'b0;
  localparam logic REG_END   = 1'b1;

  typedef struct packed {
    logic ins_req;
    logic ins_head;
    logic ins_end;
    logic prep;
    logic fetch;
    logic emit;
    logic clear;
  } sds_cmd_t;

  typedef struct packed {
    logic out_free;
    logic last_move;
  } sds_stat_t;

endpackage

`default_nettype wire

[rtl/core/sds_if.sv]
// valid/ready channel interfaces for the scan disk scheduler
// depends on sds_pkg
`default_nettype none

interface sds_in_if import sds_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] request_cylinder;
  logic              last_request;

  modport source (output valid, output request_cylinder, output last_request, input ready);
  modport sink (input valid, input request_cylinder, input last_request, output ready);
endinterface

interface sds_out_if import sds_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] from_cylinder;
  logic [DATA_W-1:0] to_cylinder;
  logic [SEEK_W-1:0] seek_total;
  logic              last_move;

  modport source (output valid, output from_cylinder, output to_cylinder,
                  output seek_total, output last_move, input ready);
  modport sink (input valid, input from_cylinder, input to_cylinder,
                input seek_total, input last_move, output ready);
endinterface

`default_nettype wire

[rtl/core/sds_datapath.sv]
// datapath: insertion-sorted cell row, walk index and seek accumulator, output register
// depends on sds_pkg and sds_out_if
`default_nettype none

module sds_datapath import sds_pkg::*; #(
  parameter int MAX_REQUESTS = MAX_REQUESTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sds_cmd_t          cmd,
  output sds_stat_t              stat,
  input  wire logic [DATA_W-1:0] request_cylinder,
  input  wire logic [DATA_W-1:0] start_cylinder,
  input  wire logic [DATA_W-1:0] end_cylinder,
  sds_out_if.source              out_if
);

  localparam int DEPTH = MAX_REQUESTS + 2;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] sorted_r [DEPTH];
  logic [DATA_W-1:0] sorted_nxt [DEPTH];
  logic [CNT_W-1:0]  cnt_r;
  logic [IDX_W-1:0]  pos_r;
  logic [IDX_W-1:0]  idx_r;
  logic              up_r;
  logic [DATA_W-1:0] prev_r;
  logic [DATA_W-1:0] rd_r;
  logic [SEEK_W-1:0] acc_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_from_r;
  logic [DATA_W-1:0] out_to_r;
  logic [SEEK_W-1:0] out_seek_r;
  logic              out_last_r;

  logic [DATA_W-1:0] ins_val;
  logic [DEPTH-1:0]  lt;
  logic [DEPTH-1:0]  lt_prev;
  logic [CNT_W-1:0]  ins_pos;
  logic              room;
  logic              ins_en;
  logic [DATA_W-1:0] delta;
  logic [SEEK_W-1:0] acc_nxt;
  logic              at_top;

  assign room   = cnt_r < CNT_W'(MAX_REQUESTS);
  assign ins_en = (cmd.ins_req && room) || cmd.ins_head || cmd.ins_end;

  always_comb begin
    priority if (cmd.ins_head) begin
      ins_val = start_cylinder;
    end else if (cmd.ins_end) begin
      ins_val = end_cylinder;
    end else begin
      ins_val = request_cylinder;
    end
  end

  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      lt[i]   = (CNT_W'(i) < cnt_r) && (sorted_r[i] < ins_val);
      ins_pos = ins_pos + CNT_W'(lt[i]);
    end
  end

  // entries below the insert point stay, the point takes the new value, the rest move up
  assign lt_prev = {lt[DEPTH-2:0], 1'b1};

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign sorted_nxt[g] = lt[g] ? sorted_r[g] : ins_val;
    end else begin : g_rest
      assign sorted_nxt[g] = lt[g] ? sorted_r[g] :
                             (lt_prev[g] ? ins_val : sorted_r[g-1]);
    end
  end

  assign delta   = (rd_r >= prev_r) ? (rd_r - prev_r) : (prev_r - rd_r);
  assign acc_nxt = acc_r + SEEK_W'(delta);
  assign at_top  = CNT_W'(idx_r) == (cnt_r - CNT_W'(1));

  assign stat.out_free  = !out_valid_r || out_if.ready;
  assign stat.last_move = up_r ? (at_top && (pos_r == '0)) : (idx_r == '0);

  always_ff @(posedge clk) begin
    if (ins_en) begin
      for (int i = 0; i < DEPTH; i++) begin
        sorted_r[i] <= sorted_nxt[i];
      end
    end
    if (cmd.ins_head) begin
      pos_r <= ins_pos[IDX_W-1:0];
    end else if (cmd.ins_end && (end_cylinder < start_cylinder)) begin
      pos_r <= pos_r + IDX_W'(1);
    end
    if (cmd.prep) begin
      prev_r <= sorted_r[pos_r];
      acc_r  <= '0;
      if ((CNT_W'(pos_r) + CNT_W'(1)) < cnt_r) begin
        idx_r <= pos_r + IDX_W'(1);
      end else begin
        idx_r <= pos_r - IDX_W'(1);
      end
    end
    if (cmd.fetch) begin
      rd_r <= sorted_r[idx_r];
    end
    if (cmd.emit) begin
      out_from_r <= prev_r;
      out_to_r   <= rd_r;
      out_seek_r <= acc_nxt;
      out_last_r <= stat.last_move;
      prev_r     <= rd_r;
      acc_r      <= acc_nxt;
      if (up_r && !at_top) begin
        idx_r <= idx_r + IDX_W'(1);
      end else begin
        idx_r <= (up_r ? pos_r : idx_r) - IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      up_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        cnt_r <= '0;
      end else if (ins_en) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (cmd.prep) begin
        up_r <= (CNT_W'(pos_r) + CNT_W'(1)) < cnt_r;
      end else if (cmd.emit && at_top) begin
        up_r <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.from_cylinder = out_from_r;
  assign out_if.to_cylinder   = out_to_r;
  assign out_if.seek_total    = out_seek_r;
  assign out_if.last_move     = out_last_r;

endmodule

`default_nettype wire

[rtl/core/sds_ctrl.sv]
// controller: batch loading, head/end insertion and move sequencing
// depends on sds_pkg
`default_nettype none

module sds_ctrl import sds_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_last,
  output logic           in_ready,
  input  wire sds_stat_t stat,
  output sds_cmd_t       cmd
);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_HEAD,
    ST_END,
    ST_PREP,
    ST_FETCH,
    ST_EMIT
  } state_t;

  state_t state_r;

  assign in_ready = state_r == ST_LOAD;

  always_comb begin
    cmd          = '0;
    cmd.ins_req  = in_valid && in_ready;
    cmd.ins_head = state_r == ST_HEAD;
    cmd.ins_end  = state_r == ST_END;
    cmd.prep     = state_r == ST_PREP;
    cmd.fetch    = state_r == ST_FETCH;
    cmd.emit     = (state_r == ST_EMIT) && stat.out_free;
    cmd.clear    = cmd.emit && stat.last_move;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      unique case (state_r)
        ST_LOAD: begin
          if (in_valid && in_last) begin
            state_r <= ST_HEAD;
          end
        end
        ST_HEAD:  state_r <= ST_END;
        ST_END:   state_r <= ST_PREP;
        ST_PREP:  state_r <= ST_FETCH;
        ST_FETCH: state_r <= ST_EMIT;
        ST_EMIT: begin
          if (stat.out_free) begin
            state_r <= stat.last_move ? ST_LOAD : ST_FETCH;
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/scan_disk_scheduler.sv]
// SCAN (elevator) disk scheduler: the request channel loads one cylinder per
// transaction; a transaction with last_request set closes the batch. The head
// position and the end cylinder are APB registers (0x0 and 0x4) and join the set.
// The block then emits one move transaction per step: up from the head to the
// top of the sorted set, then down through the entries below the head, each
// with a running seek total; last_move marks the final one.
// Loading takes one request per cycle (sorted insertion into a cell row).
// After the closing transaction the head and then the end are inserted and
// the walk is prepared; each move is then a read of the sorted row followed
// by the distance add into the output register. n requests give n+1 moves.
// Requests beyond MAX_REQUESTS are dropped. The request channel is held off
// during service; the next batch loads while the final move still waits.
// A receiver stall holds the output register and pauses the walk.
// Reset empties the batch, clears the output and loads head 0, end 199.
// depends on sds_pkg, sds_if, sds_ctrl and sds_datapath
`default_nettype none

module scan_disk_scheduler import sds_pkg::*; #(
  parameter int MAX_REQUESTS = MAX_REQUESTS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  sds_in_if.sink                     in_if,
  sds_out_if.source                  out_if,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  logic [DATA_W-1:0] start_r;
  logic [DATA_W-1:0] end_r;
  logic              cfg_wr;
  sds_cmd_t          cmd;
  sds_stat_t         stat;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= START_RESET;
      end_r   <= END_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_START: start_r <= cfg_pwdata[DATA_W-1:0];
        REG_END:   end_r   <= cfg_pwdata[DATA_W-1:0];
        default:   start_r <= start_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_START: cfg_prdata = CFG_DATA_W'(start_r);
      REG_END:   cfg_prdata = CFG_DATA_W'(end_r);
      default:   cfg_prdata = '0;
    endcase
  end

  sds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_last  (in_if.last_request),
    .in_ready (in_if.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sds_datapath #(
    .MAX_REQUESTS (MAX_REQUESTS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .request_cylinder (in_if.request_cylinder),
    .start_cylinder   (start_r),
    .end_cylinder     (end_r),
    .out_if           (out_if)
  );

endmodule

`default_nettype wire

[test/tb.sv]
// testbench for scan_disk_scheduler: request batches in, SCAN moves out
// moves are predicted per batch and checked in order, registers over the cfg port
// depends on sds_pkg, sds_if and the scheduler rtl
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sds_pkg::*;

  localparam int MAX_REQUESTS   = MAX_REQUESTS_DEF;
  localparam int SETTLE_CYCLES  = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 105;
  localparam int PRINT_LIMIT    = 30;

  localparam logic [CFG_ADDR_W-1:0] ADDR_START = {REG_START, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_END   = {REG_END, 2'b00};

  typedef enum logic [1:0] {SINK_OPEN, SINK_RANDOM, SINK_PERIODIC} sink_mode_t;

  typedef struct {
    logic [DATA_W-1:0] from_cyl;
    logic [DATA_W-1:0] to_cyl;
    logic [SEEK_W-1:0] seek;
    logic              last;
  } move_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  sds_in_if  in_ch ();
  sds_out_if out_ch ();

  scan_disk_scheduler u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  // scheduler state as seen from outside
  logic [DATA_W-1:0] head_cyl  = START_RESET;
  logic [DATA_W-1:0] sweep_end = END_RESET;
  logic [DATA_W-1:0] open_batch[$];
  logic              batch_dropped = 1'b0;
  move_t             pending_moves[$];

  int mismatches      = 0;
  int moves_checked   = 0;
  int batches_closed  = 0;
  int overflow_batches = 0;
  int reg_writes      = 0;
  int burst_left      = 0;
  bit steady_source   = 1'b0;
  int idle_cycles     = 0;

  logic       sink_ready = 1'b0;
  sink_mode_t sink_mode  = SINK_OPEN;
  logic [7:0] pattern_cnt = 8'd0;

  assign out_ch.ready = sink_ready;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  function automatic void add_move(input logic [DATA_W-1:0] from_cyl,
                                   input logic [DATA_W-1:0] to_cyl, input logic last,
                                   inout logic [SEEK_W-1:0] total);
    logic [DATA_W-1:0] delta;
    move_t mv;
    delta = (to_cyl >= from_cyl) ? to_cyl - from_cyl : from_cyl - to_cyl;
    total = total + SEEK_W'(delta);
    mv.from_cyl = from_cyl;
    mv.to_cyl   = to_cyl;
    mv.seek     = total;
    mv.last     = last;
    pending_moves.push_back(mv);
  endfunction

  // store a request; on the closing one, sort the set and queue the SCAN walk
  function automatic void schedule_request(input logic [DATA_W-1:0] cyl, input logic last);
    logic [DATA_W-1:0] cyl_set[$];
    logic [DATA_W-1:0] v;
    logic [SEEK_W-1:0] total;
    int n, j, pos, top;
    if (open_batch.size() < MAX_REQUESTS) open_batch.push_back(cyl);
    else batch_dropped = 1'b1;
    if (!last) return;
    cyl_set = open_batch;
    cyl_set.push_front(head_cyl);
    cyl_set.push_back(sweep_end);
    n = cyl_set.size();
    for (int i = 1; i < n; i++) begin
      v = cyl_set[i];
      j = i;
      while (j > 0 && cyl_set[j-1] > v) begin
        cyl_set[j] = cyl_set[j-1];
        j--;
      end
      cyl_set[j] = v;
    end
    pos = 0;
    for (int i = n - 1; i >= 0; i--) begin
      if (cyl_set[i] == head_cyl) pos = i;
    end
    total = '0;
    for (int i = pos; i + 1 < n; i++) begin
      add_move(cyl_set[i], cyl_set[i+1], (i + 2 == n) && (pos == 0), total);
    end
    top = n - 1;
    for (int i = pos; i > 0; i--) begin
      add_move(cyl_set[top], cyl_set[i-1], i == 1, total);
      top = i - 1;
    end
    batches_closed++;
    if (batch_dropped) overflow_batches++;
    open_batch.delete();
    batch_dropped = 1'b0;
  endfunction

  task automatic send_request(input logic [DATA_W-1:0] cyl, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = steady_source ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid            <= 1'b1;
    in_ch.request_cylinder <= cyl;
    in_ch.last_request     <= last;
    do @(posedge clk); while (!in_ch.ready);
    schedule_request(cyl, last);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_moves.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (addr)
      ADDR_START: head_cyl = value;
      ADDR_END:   sweep_end = value;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic read_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [DATA_W-1:0] want,
                          input string name);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= addr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[DATA_W-1:0] !== want) report(name, 32'(cfg_prdata[DATA_W-1:0]), 32'(want));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_geometry(input logic [DATA_W-1:0] head, input logic [DATA_W-1:0] limit);
    wait_idle();
    write_reg(ADDR_START, head);
    write_reg(ADDR_END, limit);
    read_reg(ADDR_START, head, "start_cylinder readback");
    read_reg(ADDR_END, limit, "end_cylinder readback");
  endtask

  task automatic test_reset_geometry();
    read_reg(ADDR_START, START_RESET, "start_cylinder reset");
    read_reg(ADDR_END, END_RESET, "end_cylinder reset");
    send_request(16'd0, 1'b1);
  endtask

  task automatic test_mixed_batch();
    set_geometry(16'd100, 16'd199);
    send_request(16'd150, 1'b0);
    send_request(16'd300, 1'b0);
    send_request(16'd100, 1'b0);
    send_request(16'd20, 1'b1);
  endtask

  task automatic test_end_below_head();
    set_geometry(16'hFFFF, 16'd0);
    send_request(16'hFFFF, 1'b0);
    send_request(16'd0, 1'b1);
  endtask

  task automatic test_full_sweep();
    set_geometry(16'd0, 16'hFFFF);
    send_request(16'h8000, 1'b1);
  endtask

  task automatic test_store_overflow();
    set_geometry(16'd500, 16'd1000);
    steady_source = 1'b1;
    for (int k = 0; k <= MAX_REQUESTS; k++) begin
      send_request(16'($urandom_range(0, 2000)), k == MAX_REQUESTS);
    end
    steady_source = 1'b0;
  endtask

  task automatic test_random_batches();
    int sent, size;
    logic [DATA_W-1:0] head, limit, cyl;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0:       head = 16'd0;
          1:       head = 16'hFFFF;
          2:       head = 16'($urandom_range(0, 255));
          default: head = 16'($urandom);
        endcase
        case ($urandom_range(0, 4))
          0:       limit = 16'd0;
          1:       limit = 16'hFFFF;
          2:       limit = END_RESET;
          3:       limit = 16'($urandom_range(0, 255));
          default: limit = 16'($urandom);
        endcase
        set_geometry(head, limit);
      end
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_REQUESTS + 1, MAX_REQUESTS + 4)
                                         : $urandom_range(1, 10);
      steady_source = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < size; k++) begin
        case ($urandom_range(0, 5))
          0:       cyl = 16'($urandom);
          1:       cyl = 16'(head_cyl + 16'($urandom_range(0, 63)));
          2:       cyl = 16'(head_cyl - 16'($urandom_range(0, 63)));
          3:       cyl = ($urandom_range(0, 1) != 0) ? head_cyl : sweep_end;
          4:       cyl = ($urandom_range(0, 1) != 0) ? 16'h0000 : 16'hFFFF;
          default: cyl = 16'($urandom_range(0, 255));
        endcase
        send_request(cyl, k == size - 1);
        sent++;
      end
    end
  endtask

  initial begin
    rst_n                  <= 1'b0;
    in_ch.valid            <= 1'b0;
    in_ch.request_cylinder <= '0;
    in_ch.last_request     <= 1'b0;
    cfg_psel               <= 1'b0;
    cfg_penable            <= 1'b0;
    cfg_pwrite             <= 1'b0;
    cfg_paddr              <= '0;
    cfg_pwdata             <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_geometry();
    test_mixed_batch();
    test_end_below_head();
    test_full_sweep();
    test_store_overflow();
    test_random_batches();
    wait_idle();
    repeat (20) @(posedge clk);
    $display("covered %0d batches (%0d over capacity) and %0d register writes",
             batches_closed, overflow_batches, reg_writes);
    $display("checked %0d moves, %0d mismatches", moves_checked, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // receiver stall pattern, switched at random among open, random and periodic modes
  always @(posedge clk) begin
    pattern_cnt <= pattern_cnt + 8'd1;
    if (pattern_cnt[5:0] == 6'd0) sink_mode <= sink_mode_t'($urandom_range(0, 2));
    case (sink_mode)
      SINK_OPEN:   sink_ready <= 1'b1;
      SINK_RANDOM: sink_ready <= ($urandom_range(0, 3) != 0);
      default:     sink_ready <= (pattern_cnt[2:0] < 3'd5);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      moves_checked++;
      if (pending_moves.size() == 0) begin
        report("unexpected move to_cylinder", 32'(out_ch.to_cylinder), 32'd0);
      end else begin
        if (out_ch.from_cylinder !== pending_moves[0].from_cyl)
          report("from_cylinder", 32'(out_ch.from_cylinder), 32'(pending_moves[0].from_cyl));
        if (out_ch.to_cylinder !== pending_moves[0].to_cyl)
          report("to_cylinder", 32'(out_ch.to_cylinder), 32'(pending_moves[0].to_cyl));
        if (out_ch.seek_total !== pending_moves[0].seek)
          report("seek_total", 32'(out_ch.seek_total), 32'(pending_moves[0].seek));
        if (out_ch.last_move !== pending_moves[0].last)
          report("last_move", 32'(out_ch.last_move), 32'(pending_moves[0].last));
        pending_moves.delete(0);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d moves outstanding",
               WATCHDOG_LIMIT, pending_moves.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule

`default_nettype wire
